// ----- src/clnw_pkg.sv -----
package clnw_pkg;

  localparam int LINE_LEN = 40;
  localparam int STORE_D  = 2 * LINE_LEN;
  localparam int ADDR_W   = $clog2(STORE_D);
  localparam int COL_W    = 6;
  localparam int HOLD_W   = 10;
  localparam int STEP_W   = 4;

  localparam logic [7:0] CMD_ROW0 = 8'h80;
  localparam logic [7:0] CMD_ROW1 = 8'hC0;

  localparam logic ACT_LOAD = 1'b1;

  localparam logic [2:0] REG_LAST_COL  = 3'd0;
  localparam logic [2:0] REG_TWO_ROWS  = 3'd1;
  localparam logic [2:0] REG_SETUP     = 3'd2;
  localparam logic [2:0] REG_EN_DATA   = 3'd3;
  localparam logic [2:0] REG_DATA_FALL = 3'd4;
  localparam logic [2:0] REG_EN_LOW    = 3'd5;

  localparam logic [STEP_W-1:0] ST_WAIT  = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_FETCH = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_PH1   = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_PH2   = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_PH3   = STEP_W'(4);
  localparam logic [STEP_W-1:0] ST_PH4   = STEP_W'(5);
  localparam logic [STEP_W-1:0] ST_PH5   = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_PH6   = STEP_W'(7);
  localparam logic [STEP_W-1:0] ST_PH7D  = STEP_W'(8);
  localparam logic [STEP_W-1:0] ST_FIN   = STEP_W'(9);

  typedef enum logic [1:0] {NIB_BUS, NIB_HI, NIB_LO} nib_sel_t;

  typedef enum logic [2:0] {HOLD_SETUP, HOLD_E2D, HOLD_D2F, HOLD_ELH, HOLD_ZERO} hold_sel_t;

  typedef enum logic [1:0] {COND_NEXT, COND_GO, COND_CMD, COND_JUMP} cond_t;

  typedef struct packed {
    logic              ready;
    logic              fetch;
    logic              emit;
    logic              en;
    nib_sel_t          nib;
    hold_sel_t         hold;
    logic              rs_zero;
    logic              last;
    logic              bus_upd;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '0;
    c.nib    = NIB_BUS;
    c.hold   = HOLD_ZERO;
    c.cond   = COND_NEXT;
    c.target = ST_WAIT;
    unique case (step)
      ST_WAIT: begin
        c.ready = 1'b1;
        c.cond  = COND_GO;
      end
      ST_FETCH: begin
        c.fetch = 1'b1;
      end
      ST_PH1: begin
        c.emit = 1'b1; c.nib = NIB_BUS; c.hold = HOLD_SETUP;
      end
      ST_PH2: begin
        c.emit = 1'b1; c.en = 1'b1; c.nib = NIB_BUS; c.hold = HOLD_E2D;
      end
      ST_PH3: begin
        c.emit = 1'b1; c.en = 1'b1; c.nib = NIB_HI; c.hold = HOLD_D2F;
      end
      ST_PH4: begin
        c.emit = 1'b1; c.nib = NIB_HI; c.hold = HOLD_ELH;
      end
      ST_PH5: begin
        c.emit = 1'b1; c.en = 1'b1; c.nib = NIB_HI; c.hold = HOLD_E2D;
      end
      ST_PH6: begin
        c.emit = 1'b1; c.en = 1'b1; c.nib = NIB_LO; c.hold = HOLD_D2F;
        c.cond = COND_CMD; c.target = ST_FIN;
      end
      ST_PH7D: begin
        c.emit = 1'b1; c.nib = NIB_LO; c.hold = HOLD_ZERO;
      end
      ST_FIN: begin
        c.emit = 1'b1; c.nib = NIB_LO; c.hold = HOLD_ELH; c.rs_zero = 1'b1;
        c.last = 1'b1; c.bus_upd = 1'b1; c.cond = COND_JUMP; c.target = ST_WAIT;
      end
      default: begin
        c.cond   = COND_JUMP;
        c.target = ST_WAIT;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- src/clnw_store.sv -----
module clnw_store
  import clnw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0]         mem_r [STORE_D];
  logic [STORE_D-1:0] valid_r;
  logic [7:0]         rd_data_r;

  // entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem_r[rd_addr] : 8'h00;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/clnw_useq.sv -----
module clnw_useq
  import clnw_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  go,
  input  logic  is_cmd,
  input  logic  stall,
  output ctrl_t ctrl
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;

  assign ctrl = ucode(step_r);

  always_comb begin
    step_nxt = step_r;
    if (!stall) begin
      unique case (ctrl.cond)
        COND_NEXT: step_nxt = step_r + STEP_W'(1);
        COND_GO:   step_nxt = go ? step_r + STEP_W'(1) : step_r;
        COND_CMD:  step_nxt = is_cmd ? ctrl.target : step_r + STEP_W'(1);
        COND_JUMP: step_nxt = ctrl.target;
        default:   step_nxt = ST_WAIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ----- src/char_lcd_refresh_nibble_writer_top.sv -----
// Load word: taken without producing any output words.
// Advance word: after accept the sequencer passes its fetch step, then pin phases are registered one per
// cycle while out_tready is high; 8 phases for a data write, 7 for a set-address command.
// A new word is accepted only in the wait step, after the last phase of the previous advance.
// Reset (rst_n low, synchronous): sequencer idle, row/column/bus nibble zero, registers at
// defaults, store valid bits cleared so the store reads zero at once; no clearing pass.
module char_lcd_refresh_nibble_writer_top
  import clnw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // row_sel[0], column_sel[6:1], char_code[14:7]
  input  logic [0:0]  in_tuser,   // action[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // reg_select[0], enable[1], data_nibble[5:2], hold_cycles[15:6]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [ADDR_W-1:0] ROW_BASE = ADDR_W'(LINE_LEN);
  localparam logic [COL_W:0]    LEN_CMP  = (COL_W + 1)'(LINE_LEN);

  logic [COL_W-1:0]  last_col_r;
  logic              two_rows_r;
  logic [HOLD_W-1:0] setup_r;
  logic [HOLD_W-1:0] en_data_r;
  logic [HOLD_W-1:0] data_fall_r;
  logic [HOLD_W-1:0] en_low_r;

  logic              cur_row_r;
  logic [COL_W-1:0]  cur_col_r;
  logic [3:0]        bus_nib_r;
  logic              cmd_r;
  logic              oob_r;
  logic [7:0]        byte_r;

  logic              out_valid_r;
  logic [15:0]       out_data_r;
  logic              out_last_r;

  ctrl_t             ctrl;
  logic              accept;
  logic              go;
  logic              stall;
  logic              load_out;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  logic              in_row;
  logic [COL_W-1:0]  in_col;
  logic [7:0]        in_char;
  logic              col_over;
  logic              cur_in_line;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  logic              ph_rs;
  logic [3:0]        ph_nib;
  logic [HOLD_W-1:0] ph_hold;

  assign in_row  = in_tdata[0];
  assign in_col  = in_tdata[6:1];
  assign in_char = in_tdata[14:7];

  assign in_tready = ctrl.ready;
  assign accept    = in_tvalid & in_tready;
  assign go        = accept & (in_tuser[0] != ACT_LOAD);

  // store ports
  assign wr_en   = accept & (in_tuser[0] == ACT_LOAD) & ({1'b0, in_col} < LEN_CMP);
  assign wr_addr = (in_row ? ROW_BASE : '0) + ADDR_W'(in_col);

  assign col_over    = cur_col_r > last_col_r;
  assign cur_in_line = {1'b0, cur_col_r} < LEN_CMP;
  assign rd_en       = go & !col_over & cur_in_line;
  assign rd_addr     = (cur_row_r ? ROW_BASE : '0) + ADDR_W'(cur_col_r);

  clnw_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_char),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  clnw_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .is_cmd (cmd_r),
    .stall  (stall),
    .ctrl   (ctrl)
  );

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r  <= COL_W'(15);
      two_rows_r  <= 1'b1;
      setup_r     <= HOLD_W'(16);
      en_data_r   <= HOLD_W'(16);
      data_fall_r <= HOLD_W'(16);
      en_low_r    <= HOLD_W'(16);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LAST_COL:  last_col_r  <= cfg_pwdata[COL_W-1:0];
        REG_TWO_ROWS:  two_rows_r  <= cfg_pwdata[0];
        REG_SETUP:     setup_r     <= cfg_pwdata[HOLD_W-1:0];
        REG_EN_DATA:   en_data_r   <= cfg_pwdata[HOLD_W-1:0];
        REG_DATA_FALL: data_fall_r <= cfg_pwdata[HOLD_W-1:0];
        REG_EN_LOW:    en_low_r    <= cfg_pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LAST_COL:  cfg_prdata = 32'(last_col_r);
      REG_TWO_ROWS:  cfg_prdata = 32'(two_rows_r);
      REG_SETUP:     cfg_prdata = 32'(setup_r);
      REG_EN_DATA:   cfg_prdata = 32'(en_data_r);
      REG_DATA_FALL: cfg_prdata = 32'(data_fall_r);
      REG_EN_LOW:    cfg_prdata = 32'(en_low_r);
      default:       cfg_prdata = 32'h0;
    endcase
  end

  // refresh position and byte to send
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= 1'b0;
      cur_col_r <= '0;
      bus_nib_r <= 4'h0;
      cmd_r     <= 1'b0;
      oob_r     <= 1'b0;
    end else begin
      if (go) begin
        if (col_over) begin
          cmd_r     <= 1'b1;
          cur_col_r <= '0;
          cur_row_r <= !cur_row_r & two_rows_r;
        end else begin
          cmd_r     <= 1'b0;
          oob_r     <= !cur_in_line;
          cur_col_r <= cur_col_r + COL_W'(1);
        end
      end
      if (ctrl.bus_upd && load_out) begin
        bus_nib_r <= byte_r[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && col_over) begin
      byte_r <= (!cur_row_r && two_rows_r) ? CMD_ROW1 : CMD_ROW0;
    end else if (ctrl.fetch && !cmd_r) begin
      byte_r <= oob_r ? 8'h00 : rd_data;
    end
  end

  // phase word
  assign ph_rs = ctrl.rs_zero ? 1'b0 : !cmd_r;

  always_comb begin
    unique case (ctrl.nib)
      NIB_BUS: ph_nib = bus_nib_r;
      NIB_HI:  ph_nib = byte_r[7:4];
      NIB_LO:  ph_nib = byte_r[3:0];
      default: ph_nib = bus_nib_r;
    endcase
  end

  always_comb begin
    unique case (ctrl.hold)
      HOLD_SETUP: ph_hold = setup_r;
      HOLD_E2D:   ph_hold = en_data_r;
      HOLD_D2F:   ph_hold = data_fall_r;
      HOLD_ELH:   ph_hold = en_low_r;
      HOLD_ZERO:  ph_hold = '0;
      default:    ph_hold = '0;
    endcase
  end

  // output register
  assign load_out = ctrl.emit & (!out_valid_r | out_tready);
  assign stall    = ctrl.emit & !load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {ph_hold, ph_nib, ctrl.en, ph_rs};
      out_last_r <= ctrl.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
